// ===== rtl/core/ncq_pkg.sv =====
// Shared types and constants for the nearest-center quantizer.
// Sequencer states, opcodes, config register indexes and fixed-point constants.
// No dependencies.
package ncq_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RDN,
    S_LATN,
    S_SCAN,
    S_DIFF,
    S_MAG,
    S_MUL,
    S_CMP,
    S_OUT
  } ncq_state_t;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Metric modes
  localparam logic MODE_WEIGHTED = 1'b0;
  localparam logic MODE_ANGLE    = 1'b1;

  // Config register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_METRIC_MODE    = 2'd0;
  localparam cfg_idx_t CFG_CENTERS_IN_USE = 2'd1;

  // Q16.16 angle constants, rounded to nearest
  localparam int PI_Q16     = 205887;
  localparam int TWO_PI_Q16 = 411775;

  // Distances are unsigned Q32.16
  typedef logic [47:0] dist_t;
  localparam dist_t DIST_MAX = '1;

endpackage

// ===== rtl/core/nearest_center_quantizer.sv =====
// Nearest-center quantizer: center table, search sequencer and shared distance unit.
// Depends on ncq_pkg.
// Throughput: one query at a time; in weighted mode the between-scan reads one table mean per
//   cycle through the single read port, so the scan over C means for each of C centers sets it.
// Reset (synchronous, rst_n low): metric_mode=0, centers_in_use=1, idle, no result held.
//   The center table is not cleared; entries read back undefined until written.
module nearest_center_quantizer #(
  parameter int NUM_CENTERS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [2:0]              in_entry_index,
  input  logic signed [31:0]      in_center_value,
  input  logic [31:0]             in_center_weight,
  input  logic signed [31:0]      in_sample,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_nearest_index,
  output ncq_pkg::dist_t          out_best_distance,
  // config write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  ncq_pkg::cfg_idx_t       cfg_index,
  input  logic [31:0]             cfg_wdata
);
  import ncq_pkg::*;

  localparam int AW = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
  localparam int CW = $clog2(NUM_CENTERS + 1);

  localparam logic signed [33:0] PI_S     = 34'(PI_Q16);
  localparam logic signed [33:0] NEG_PI_S = -34'(PI_Q16);
  localparam logic signed [33:0] TWO_PI_S = 34'(TWO_PI_Q16);

  // One wrap correction, then magnitude
  function automatic logic [33:0] wrap_mag(input logic signed [33:0] d);
    logic signed [33:0] w;
    if (d > PI_S) begin
      w = d - TWO_PI_S;
    end else if (d <= NEG_PI_S) begin
      w = d + TWO_PI_S;
    end else begin
      w = d;
    end
    return w[33] ? $unsigned(-w) : $unsigned(w);
  endfunction

  ncq_state_t state_r, state_nxt;

  logic               mode_r;
  logic [3:0]         cnt_cfg_r;

  logic               q_mode_r;
  logic signed [31:0] x_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      k_r;
  logic               rd_v_r;
  logic               blocked_r;
  logic signed [31:0] mn_r;
  logic [31:0]        wn_r;
  logic signed [32:0] diff_r;
  logic [31:0]        mag_r;
  logic [33:0]        ang_a_r;
  logic [33:0]        ang_b_r;
  logic [63:0]        prod_r;
  logic               found_r;
  logic [CW-1:0]      best_r;
  dist_t              best_d_r;

  logic               out_valid_r;
  logic [2:0]         out_idx_r;
  dist_t              out_dist_r;

  // center table
  logic [31:0]        mean_mem [NUM_CENTERS];
  logic [31:0]        wt_mem   [NUM_CENTERS];
  logic [31:0]        rd_mean_r;
  logic [31:0]        rd_wt_r;

  // control decode
  logic               in_xfer;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               out_load;
  logic [CW-1:0]      count_clamp;
  logic               tbl_wr;
  logic               between;
  logic signed [31:0] mk;
  dist_t              cur_d;
  logic [33:0]        ang_min;
  logic               take;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;

  // clamp count to 1..NUM_CENTERS
  always_comb begin
    if (cnt_cfg_r == 4'd0) begin
      count_clamp = CW'(1);
    end else if (32'(cnt_cfg_r) > NUM_CENTERS) begin
      count_clamp = CW'(NUM_CENTERS);
    end else begin
      count_clamp = CW'(cnt_cfg_r);
    end
  end

  assign tbl_wr = in_xfer && (in_opcode == OP_WRITE) && (32'(in_entry_index) < NUM_CENTERS);

  // between test on the mean read during the scan
  assign mk      = $signed(rd_mean_r);
  assign between = ((mn_r < mk) && (mk < x_r)) || ((x_r < mk) && (mk < mn_r));

  // candidate distance
  assign ang_min = (ang_a_r < ang_b_r) ? ang_a_r : ang_b_r;
  assign cur_d   = (q_mode_r == MODE_ANGLE) ? 48'(ang_min) : prod_r[63:16];
  assign take    = ((q_mode_r == MODE_ANGLE) || !blocked_r) && (!found_r || (cur_d < best_d_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_opcode == OP_QUERY)) state_nxt = S_RDN;
      end
      S_RDN:  state_nxt = S_LATN;
      S_LATN: state_nxt = (q_mode_r == MODE_ANGLE) ? S_DIFF : S_SCAN;
      S_SCAN: begin
        if ((k_r == count_r) && !rd_v_r) state_nxt = blocked_r ? S_CMP : S_DIFF;
      end
      S_DIFF: state_nxt = S_MAG;
      S_MAG:  state_nxt = (q_mode_r == MODE_ANGLE) ? S_CMP : S_MUL;
      S_MUL:  state_nxt = S_CMP;
      S_CMP:  state_nxt = ((n_r + CW'(1)) == count_r) ? S_OUT : S_RDN;
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = n_r[AW-1:0];
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_RDN:  rd_en = 1'b1;
      S_SCAN: begin
        rd_addr = k_r[AW-1:0];
        rd_en   = (k_r != count_r);
      end
      S_OUT:  out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_WEIGHTED;
      cnt_cfg_r   <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_METRIC_MODE:    mode_r    <= cfg_wdata[0];
          CFG_CENTERS_IN_USE: cnt_cfg_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // center table write and registered read
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      mean_mem[AW'(in_entry_index)] <= in_center_value;
      wt_mem[AW'(in_entry_index)]   <= in_center_weight;
    end
    if (rd_en) begin
      rd_mean_r <= mean_mem[rd_addr];
      rd_wt_r   <= wt_mem[rd_addr];
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_opcode == OP_QUERY)) begin
          x_r      <= in_sample;
          q_mode_r <= mode_r;
          count_r  <= count_clamp;
          n_r      <= '0;
          found_r  <= 1'b0;
          best_r   <= '0;
          best_d_r <= DIST_MAX;
        end
      end
      S_LATN: begin
        mn_r      <= $signed(rd_mean_r);
        wn_r      <= rd_wt_r;
        k_r       <= '0;
        rd_v_r    <= 1'b0;
        blocked_r <= 1'b0;
      end
      S_SCAN: begin
        rd_v_r <= rd_en;
        if (rd_en) k_r <= k_r + CW'(1);
        if (rd_v_r && between) blocked_r <= 1'b1;
      end
      S_DIFF: diff_r <= {x_r[31], x_r} - {mn_r[31], mn_r};
      S_MAG: begin
        mag_r   <= diff_r[32] ? 32'(-diff_r) : diff_r[31:0];
        ang_a_r <= wrap_mag(34'(diff_r));
        ang_b_r <= wrap_mag(-34'(diff_r));
      end
      S_MUL:  prod_r <= 64'(mag_r) * 64'(wn_r);
      S_CMP: begin
        if (take) begin
          found_r  <= 1'b1;
          best_r   <= n_r;
          best_d_r <= cur_d;
        end
        n_r <= n_r + CW'(1);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= found_r ? 3'(best_r) : 3'd0;
      out_dist_r <= found_r ? best_d_r : DIST_MAX;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;
  assign out_best_distance = out_dist_r;

  // the center nearest the sample is never excluded
  a_found_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> found_r)
    else $error("query finished without a surviving center");

  // scan index never runs past the searched count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r <= count_r))
    else $error("scan index beyond count");

  // center index stays inside the searched range while searching
  a_center_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RDN) || (state_r == S_CMP)) |->
      ((n_r < count_r) && (count_r != '0) && (32'(count_r) <= NUM_CENTERS)))
    else $error("center index out of range");

  // a query starts its search at center zero
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_opcode == OP_QUERY)) |=> ((state_r == S_RDN) && (n_r == '0)))
    else $error("query did not start at center zero");

endmodule

// ===== bench/nearest_center_quantizer_test.sv =====
// Self-checking bench for nearest_center_quantizer: a directed table, then random phases.
// Every query is checked against the expected result typed in its row or an in-bench search.
// Depends on ncq_pkg and the nearest_center_quantizer RTL.
module nearest_center_quantizer_test;
  import ncq_pkg::*;

  localparam int RAND_ITEMS    = 1200;
  localparam int SETTLE_CYCLES = 130;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1000000;

  // Unused register indexes, written to show they are ignored
  localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
  localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_data;
    logic        op;
    logic [2:0]  entry;
    logic [31:0] value;
    logic [31:0] weight;
    logic [31:0] smp;
    logic        typed;     // expected result given in the row
    logic [2:0]  t_idx;
    dist_t       t_dist;
  } row_t;

  typedef struct {
    logic [2:0] idx;
    dist_t      distance;
  } nearest_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_opcode;
  logic [2:0]        in_entry_index;
  logic signed [31:0] in_center_value;
  logic [31:0]       in_center_weight;
  logic signed [31:0] in_sample;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        out_nearest_index;
  dist_t             out_best_distance;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_idx_t          cfg_index;
  logic [31:0]       cfg_wdata;

  nearest_center_quantizer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_center_value   (in_center_value),
    .in_center_weight  (in_center_weight),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nearest_index (out_nearest_index),
    .out_best_distance (out_best_distance),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Bench copy of the block's registers and center table
  logic              mode_reg;
  logic [3:0]        count_reg;
  logic signed [31:0] mean_tbl [8];
  logic [31:0]       weight_tbl [8];

  nearest_t pending_nearest [$];
  int       fail_count;
  int       cycle_count;
  int       rand_sent;
  bit       idle_on;
  bit       tail_quiet;
  bit       hold_req;
  bit       hold_active;
  bit       hold_done;

  // Directed table. Columns: kind, reg index, reg data, opcode, entry, mean, weight,
  // sample, typed, expected index, expected distance.
  localparam int NUM_ROWS = 29;
  row_t directed_rows [NUM_ROWS] = '{
    // one center after reset, weighted, count 1
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd0, 32'd0, 32'h0001_0000, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'h0005_0000,
      1'b1, 3'd0, 48'd327680},
    // extreme mean, weight and sample
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'h7FFF_FFFF,
      1'b1, 3'd0, 48'hFFFF_FFFE_0000},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'h8000_0000,
      1'b1, 3'd0, 48'd0},
    // fill the rest of the table: tie pair, symmetric pair, zero weights
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd1, 32'h000A_0000, 32'h0001_0000, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd2, 32'h0014_0000, 32'h0000_8000, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd3, 32'h0014_0000, 32'h0000_8000, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd4, 32'hFFFF_0000, 32'h0001_0000, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd5, 32'h0001_0000, 32'h0001_0000, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd6, 32'h7FFF_FFFF, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_WRITE, 3'd7, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    // full table, plus ignored register indexes
    '{ROW_CFG, CFG_CENTERS_IN_USE, 32'd8, OP_WRITE, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_CFG, CFG_SPARE_2, 32'hFFFF_FFFF, OP_WRITE, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_CFG, CFG_SPARE_3, 32'd0, OP_WRITE, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    // between-exclusion: nearer means shadow the far ones
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'h001E_0000,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'h000F_0000,
      1'b0, 3'd0, 48'd0},
    // angle mode, including samples at and beyond +-pi
    '{ROW_CFG, CFG_METRIC_MODE, 32'd1, OP_WRITE, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'(PI_Q16),
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'(-PI_Q16),
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'h7FFF_FFFF,
      1'b0, 3'd0, 48'd0},
    // count of zero behaves as one
    '{ROW_CFG, CFG_CENTERS_IN_USE, 32'hFFFF_FFF0, OP_WRITE, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'h0001_0000,
      1'b0, 3'd0, 48'd0},
    // count above the table size clamps; weighted mode with high data bits set
    '{ROW_CFG, CFG_CENTERS_IN_USE, 32'd15, OP_WRITE, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    '{ROW_CFG, CFG_METRIC_MODE, 32'hFFFF_FFFE, OP_WRITE, 3'd0, 32'd0, 32'd0, 32'd0,
      1'b0, 3'd0, 48'd0},
    // exact tie between entries 2 and 3 keeps the lower one
    '{ROW_ITEM, CFG_METRIC_MODE, 32'd0, OP_QUERY, 3'd0, 32'd0, 32'd0, 32'h0014_0000,
      1'b0, 3'd0, 48'd0}
  };

  // Clock, period 4
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Single angle wrap correction
  function automatic longint wrap_angle(input longint d);
    if (d > PI_Q16) return d - TWO_PI_Q16;
    if (d <= -PI_Q16) return d + TWO_PI_Q16;
    return d;
  endfunction

  function automatic longint unsigned magnitude(input longint d);
    return (d < 0) ? longint'(-d) : d;
  endfunction

  // Nearest-center search over the bench table
  function automatic nearest_t search_nearest(input logic signed [31:0] smp);
    nearest_t         res;
    int               cnt;
    int               best;
    longint           x;
    longint           mn;
    longint           mk;
    longint unsigned  a;
    longint unsigned  b;
    longint unsigned  d;
    longint unsigned  best_d;
    bit               found;
    bit               blocked;
    cnt = count_reg;
    if (cnt < 1) cnt = 1;
    if (cnt > 8) cnt = 8;
    x = smp;
    found = 1'b0;
    best = 0;
    best_d = DIST_MAX;
    for (int n = 0; n < cnt; n++) begin
      mn = mean_tbl[n];
      if (mode_reg == MODE_ANGLE) begin
        a = magnitude(wrap_angle(x - mn));
        b = magnitude(wrap_angle(mn - x));
        d = (a < b) ? a : b;
      end else begin
        blocked = 1'b0;
        for (int k = 0; k < cnt; k++) begin
          mk = mean_tbl[k];
          if ((mn < mk && mk < x) || (x < mk && mk < mn)) blocked = 1'b1;
        end
        if (blocked) continue;
        d = (magnitude(x - mn) * longint'({32'd0, weight_tbl[n]})) >> 16;
      end
      if (d > DIST_MAX) d = DIST_MAX;
      if (!found || d < best_d) begin
        found = 1'b1;
        best_d = d;
        best = n;
      end
    end
    if (!found) begin
      best = 0;
      best_d = DIST_MAX;
    end
    res.idx = best[2:0];
    res.distance = best_d[47:0];
    return res;
  endfunction

  // Random coordinate: extremes, coarse grid for ties, clustered values
  function automatic logic [31:0] pick_coord(input logic angle);
    logic [31:0] v;
    case ($urandom_range(0, 11))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2, 3: v = $urandom;
      4, 5: v = ($urandom_range(0, 8) - 4) << 16;
      6: v = $urandom_range(0, 1) ? 32'(PI_Q16) : 32'(-PI_Q16);
      default: begin
        if (angle) v = $urandom_range(0, 2 * PI_Q16) - PI_Q16;
        else v = $urandom_range(0, 80 << 16) - (40 << 16);
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_weight();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'd0;
      1: w = 32'hFFFF_FFFF;
      2: w = $urandom;
      default: w = $urandom_range(32'h1000, 32'h4_0000);
    endcase
    return w;
  endfunction

  // Update the bench state for an accepted item
  task automatic record_transfer(input row_t r);
    nearest_t e;
    if (r.op == OP_WRITE) begin
      mean_tbl[r.entry] = r.value;
      weight_tbl[r.entry] = r.weight;
    end else if (r.typed) begin
      e.idx = r.t_idx;
      e.distance = r.t_dist;
      pending_nearest.push_back(e);
    end else begin
      pending_nearest.push_back(search_nearest(r.smp));
    end
  endtask

  // Offer one item, with an optional idle burst ahead of it
  task automatic offer_item(input row_t r);
    int gap;
    if (!tail_quiet && !hold_active && idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_opcode = r.op;
    in_entry_index = r.entry;
    in_center_value = r.value;
    in_center_weight = r.weight;
    in_sample = r.smp;
    do @(posedge clk); while (in_stall);
    record_transfer(r);
  endtask

  // Register write transfer
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_METRIC_MODE) mode_reg = data[0];
    else if (idx == CFG_CENTERS_IN_USE) count_reg = data[3:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every query has answered and a trailing write has retired
  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    nearest_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_nearest.size() == 0) begin
        $error("unexpected result: index %0d distance %0h",
               out_nearest_index, out_best_distance);
        fail_count++;
      end else begin
        e = pending_nearest.pop_front();
        if (out_nearest_index !== e.idx) begin
          $error("nearest_index: expected %0d, got %0d", e.idx, out_nearest_index);
          fail_count++;
        end
        if (out_best_distance !== e.distance) begin
          $error("best_distance: expected %0h, got %0h", e.distance, out_best_distance);
          fail_count++;
        end
      end
    end
  end

  // Result-side stall: random bursts, one long hold-off, none in the tail
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_active = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_active = 1'b0;
        hold_done = 1'b1;
      end else if (tail_quiet || $urandom_range(0, 1) == 0) begin
        out_stall = 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end else begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end
    end
  end

  // Main sequence
  initial begin
    row_t        r;
    int          phase;
    int          plen;
    int          cnt;
    logic [31:0] data;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_WRITE;
    in_entry_index = '0;
    in_center_value = '0;
    in_center_weight = '0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_METRIC_MODE;
    cfg_wdata = '0;
    mode_reg = MODE_WEIGHTED;
    count_reg = 4'd1;
    fail_count = 0;
    cycle_count = 0;
    rand_sent = 0;
    idle_on = 1'b1;
    tail_quiet = 1'b0;
    hold_req = 1'b0;
    hold_active = 1'b0;
    hold_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table; entry 0 is loaded before the first query and
    // every entry before the search widens
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        offer_item(directed_rows[i]);
      end
    end

    // Random phases, each under its own register setting
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      settle_idle();
      data = $urandom;
      data[0] = $urandom_range(0, 1);
      write_reg(CFG_METRIC_MODE, data);
      case (phase % 6)
        0: cnt = 8;
        1: cnt = 1;
        3: cnt = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
        default: cnt = $urandom_range(1, 8);
      endcase
      data = $urandom;
      data[3:0] = cnt[3:0];
      write_reg(CFG_CENTERS_IN_USE, data);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);

      // Phase 2 carries the long result-side hold-off
      if (phase == 2) hold_req = 1'b1;
      plen = (phase == 2) ? 120 : $urandom_range(40, 120);
      idle_on = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < plen && rand_sent < RAND_ITEMS; k++) begin
        r = '0;
        r.kind = ROW_ITEM;
        r.op = ($urandom_range(0, 99) < 35) ? OP_WRITE : OP_QUERY;
        r.entry = $urandom_range(0, 7);
        r.value = pick_coord(mode_reg);
        r.weight = pick_weight();
        r.smp = pick_coord(mode_reg);
        offer_item(r);
        rand_sent++;
        tail_quiet = (rand_sent >= RAND_ITEMS * 85 / 100);
      end
      phase++;
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
